// File: hw/rtl/qtl_pkg.sv
// Shared types, character constants and classifiers for the query token lexer.
// Used by the lexer top level and its checker; no dependencies of its own.
`default_nettype none

package qtl_pkg;

  // Number of result words one input character can cause at most.
  localparam int unsigned MaxRes = 3;

  // Token kinds as they appear on the result channel.
  typedef enum logic [2:0] {
    K_OPEN    = 3'd0,
    K_CLOSE   = 3'd1,
    K_COMMA   = 3'd2,
    K_STRING  = 3'd3,
    K_NUMBER  = 3'd4,
    K_KEYWORD = 3'd5,
    K_ERROR   = 3'd6,
    K_END     = 3'd7
  } kind_e;

  // Lexer modes between characters.
  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_NUM  = 3'd1,
    M_KEY  = 3'd2,
    M_STR0 = 3'd3,
    M_STR  = 3'd4,
    M_DISC = 3'd5
  } mode_e;

  // One result word.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       ch_valid;
    logic       token_done;
    logic       run_last;
  } res_t;

  localparam res_t RES_NONE = '{
    kind: K_OPEN, ch: 8'h00, ch_valid: 1'b0, token_done: 1'b0, run_last: 1'b0
  };

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic res_t mk_res(kind_e k, logic [7:0] c, logic v, logic d);
    res_t r;
    r = RES_NONE;
    r.kind       = k;
    r.ch         = c;
    r.ch_valid   = v;
    r.token_done = d;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qtl_if.sv
// Valid/ready channel interfaces for the query token lexer.
// qtl_in_if carries text characters, qtl_out_if carries result words.
`default_nettype none

interface qtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch_in;
  logic       text_end;

  modport source (output valid, output ch_in, output text_end, input ready);
  modport sink   (input valid, input ch_in, input text_end, output ready);
endinterface

interface qtl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] ch_out;
  logic       ch_valid;
  logic       token_done;
  logic       run_last;

  modport source (output valid, output kind, output ch_out, output ch_valid,
                  output token_done, output run_last, input ready);
  modport sink   (input valid, input kind, input ch_out, input ch_valid,
                  input token_done, input run_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/query_token_lexer.sv
// Query token lexer: turns a character stream into a stream of token words.
// Depends on qtl_pkg and the channel interfaces in qtl_if.sv.
//
// Usage: characters enter on in_i, one word per character, with text_end
// marking the last one (ch_in 0 together with text_end means no character).
// Each character yields zero to three result words on out_o: token
// characters with their kind, token-closing markers, an error word or an
// end-of-text word. run_last flags the final word caused by one character.
// The words for a character are classified in the cycle it is accepted and the
// first one is shown on out_o in the next cycle.
// Throughput: one character per cycle while each character gives at most one
// word and the receiver is ready; a character that gives more words keeps the
// input waiting, since the three-entry result buffer drains one word per cycle
// while ready is high and the next character is taken in the cycle its last
// word leaves. Reset puts the lexer between tokens with no pending space and
// empties the result buffer. When the receiver stalls, the current word holds
// on out_o and no new character is taken until the last buffered word leaves.
`default_nettype none

module query_token_lexer import qtl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qtl_in_if.sink     in_i,
  qtl_out_if.source  out_o
);

  // Lexer state.
  mode_e mode_q, mode_d;
  logic  space_q, space_d;

  // Result buffer: words of the last accepted character, read out in order.
  res_t       buf_q [MaxRes];
  logic [1:0] rd_q;
  logic [1:0] cnt_q;

  // Classification results for the character on the input.
  res_t       res   [MaxRes];
  logic [1:0] n_res;
  logic       has_ch;
  logic       start;
  kind_e      open_kind;
  logic [7:0] c;
  logic       last;
  logic       in_acc;
  logic       out_pop;

  assign c    = in_i.ch_in;
  assign last = in_i.text_end;

  // Take a character when the buffer is empty or its final word leaves now.
  assign out_pop = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign in_acc = in_i.valid && in_i.ready;

  // Classify one character and build its result words.
  always_comb begin
    res       = '{default: RES_NONE};
    n_res     = 2'd0;
    mode_d    = mode_q;
    space_d   = space_q;
    start     = 1'b0;
    open_kind = K_NUMBER;
    has_ch    = !(last && (c == CH_NUL));

    if (has_ch) begin
      unique case (mode_q)
        M_NUM: begin
          if (is_digit(c)) begin
            res[n_res] = mk_res(K_NUMBER, c, 1'b1, 1'b0);
            n_res = n_res + 2'd1;
          end else begin
            res[n_res] = mk_res(K_NUMBER, CH_NUL, 1'b0, 1'b1);
            n_res = n_res + 2'd1;
            mode_d = M_IDLE;
            start = 1'b1;
          end
        end
        M_KEY: begin
          if (is_letter(c)) begin
            res[n_res] = mk_res(K_KEYWORD, c, 1'b1, 1'b0);
            n_res = n_res + 2'd1;
          end else begin
            res[n_res] = mk_res(K_KEYWORD, CH_NUL, 1'b0, 1'b1);
            n_res = n_res + 2'd1;
            mode_d = M_IDLE;
            start = 1'b1;
          end
        end
        M_STR0: begin
          if (c == CH_QUOTE) begin
            res[n_res] = mk_res(K_ERROR, CH_NUL, 1'b0, 1'b0);
            n_res = n_res + 2'd1;
            mode_d = M_DISC;
          end else if (!last) begin
            res[n_res] = mk_res(K_STRING, c, 1'b1, 1'b0);
            n_res = n_res + 2'd1;
            mode_d = M_STR;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            res[n_res] = mk_res(K_STRING, CH_NUL, 1'b0, 1'b1);
            n_res = n_res + 2'd1;
            mode_d = M_IDLE;
          end else if (!last) begin
            res[n_res] = mk_res(K_STRING, c, 1'b1, 1'b0);
            n_res = n_res + 2'd1;
          end
        end
        M_IDLE: start = 1'b1;
        M_DISC: ;
        default: ;
      endcase

      // The character opens a new token, or is a separator, from idle.
      if (start) begin
        if (c == CH_SPACE) begin
          space_d = 1'b1;
        end else begin
          space_d = 1'b0;
          priority if (c == CH_OPEN) begin
            res[n_res] = mk_res(K_OPEN, c, 1'b1, 1'b1);
            n_res = n_res + 2'd1;
          end else if (c == CH_CLOSE) begin
            res[n_res] = mk_res(K_CLOSE, c, 1'b1, 1'b1);
            n_res = n_res + 2'd1;
          end else if (c == CH_COMMA) begin
            res[n_res] = mk_res(K_COMMA, c, 1'b1, 1'b1);
            n_res = n_res + 2'd1;
          end else if (c == CH_QUOTE) begin
            mode_d = M_STR0;
          end else if (is_digit(c)) begin
            mode_d = M_NUM;
            res[n_res] = mk_res(K_NUMBER, c, 1'b1, 1'b0);
            n_res = n_res + 2'd1;
          end else if (is_letter(c)) begin
            mode_d = M_KEY;
            res[n_res] = mk_res(K_KEYWORD, c, 1'b1, 1'b0);
            n_res = n_res + 2'd1;
          end else begin
            res[n_res] = mk_res(K_ERROR, CH_NUL, 1'b0, 1'b0);
            n_res = n_res + 2'd1;
            mode_d = M_DISC;
          end
        end
      end
    end

    // End of text closes an open token and reports how the text ended.
    if (last) begin
      if ((mode_d == M_NUM) || (mode_d == M_KEY)) begin
        open_kind = (mode_d == M_NUM) ? K_NUMBER : K_KEYWORD;
        if ((n_res != 2'd0) && res[n_res - 2'd1].ch_valid &&
            (res[n_res - 2'd1].kind == open_kind)) begin
          res[n_res - 2'd1].token_done = 1'b1;
        end else begin
          res[n_res] = mk_res(open_kind, CH_NUL, 1'b0, 1'b1);
          n_res = n_res + 2'd1;
        end
        mode_d = M_IDLE;
      end
      if ((mode_d == M_STR0) || (mode_d == M_STR) ||
          ((mode_d == M_IDLE) && space_d)) begin
        res[n_res] = mk_res(K_ERROR, CH_NUL, 1'b0, 1'b0);
        n_res = n_res + 2'd1;
      end else if (mode_d == M_IDLE) begin
        res[n_res] = mk_res(K_END, CH_NUL, 1'b0, 1'b0);
        n_res = n_res + 2'd1;
      end
      mode_d  = M_IDLE;
      space_d = 1'b0;
    end

    if (n_res != 2'd0) begin
      res[n_res - 2'd1].run_last = 1'b1;
    end
  end

  // Lexer state and buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      space_q <= 1'b0;
      rd_q    <= 2'd0;
      cnt_q   <= 2'd0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      space_q <= space_d;
      rd_q    <= 2'd0;
      cnt_q   <= n_res;
    end else if (out_pop) begin
      rd_q    <= rd_q + 2'd1;
      cnt_q   <= cnt_q - 2'd1;
    end
  end

  // Result words of the accepted character.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q <= res;
    end
  end

  // Present the word at the read pointer.
  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.kind       = buf_q[rd_q].kind;
  assign out_o.ch_out     = buf_q[rd_q].ch;
  assign out_o.ch_valid   = buf_q[rd_q].ch_valid;
  assign out_o.token_done = buf_q[rd_q].token_done;
  assign out_o.run_last   = buf_q[rd_q].run_last;

endmodule

`default_nettype wire

// File: hw/rtl/qtl_checker.sv
// Port-level checks for the query token lexer, attached by a bind statement.
// Depends on qtl_pkg and the query_token_lexer top level.
`default_nettype none

module qtl_checker import qtl_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] kind_i,
  input wire logic [7:0] ch_out_i,
  input wire logic       ch_valid_i,
  input wire logic       token_done_i,
  input wire logic       run_last_i
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(ch_out_i) && $stable(ch_valid_i) && $stable(token_done_i) &&
      $stable(run_last_i))
    else $error("result word changed while stalled");

  // An empty result buffer always takes the next character.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready with empty result buffer");

  // An error word is the last word of its character and closes no token.
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == K_ERROR) |-> run_last_i && !token_done_i && !ch_valid_i)
    else $error("malformed error word");

  // End of text is the last word of its character and carries no character.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == K_END) |-> run_last_i && !token_done_i && !ch_valid_i)
    else $error("malformed end-of-text word");

  // A token word without a character is a closing marker.
  a_marker_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ch_valid_i && (kind_i != K_ERROR) && (kind_i != K_END)
      |-> token_done_i)
    else $error("token word without character does not close the token");

endmodule

bind query_token_lexer qtl_checker u_qtl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .ch_out_i     (out_o.ch_out),
  .ch_valid_i   (out_o.ch_valid),
  .token_done_i (out_o.token_done),
  .run_last_i   (out_o.run_last)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for query_token_lexer: directed texts, then random texts.
// Depends on qtl_pkg, the channel interfaces in qtl_if.sv and the lexer top level.

module tb;
  import qtl_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumChars   = 260;

  // One character of stimulus, with an optional typed-in expected word.
  typedef struct {
    logic [7:0] ch;
    logic       te;
    logic       typed;
    res_t       want;
  } char_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cyc_cnt = 0;

  qtl_in_if  in_if ();
  qtl_out_if out_if ();

  query_token_lexer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted lexer state.
  mode_e lx_mode;
  logic  sp_pend;

  res_t      step_q[$];
  res_t      words_due[$];
  char_row_t rows_q[$];
  char_row_t text_q[$];

  int       n_errs = 0;
  int       n_words = 0;
  int       n_chars = 0;
  int       n_texts = 0;
  int       max_burst = 0;
  bit [7:0] kinds_seen = '0;
  bit       press_go = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // Watchdog on the cycle counter.
  initial begin
    while (cyc_cnt < CycleLimit) @(posedge clk_i);
    $display("%0t: timeout with %0d words still due", $time, words_due.size());
    $display("** query_token_lexer: FAILED **");
    $finish;
  end

  // Idle gaps: mostly none or short, a few long, and none in calm stretches.
  function automatic int pick_gap();
    int r;
    if (cyc_cnt[9:8] == 2'b11) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic res_t word(kind_e k, logic [7:0] c, logic v, logic d, logic l);
    res_t r;
    r.kind       = k;
    r.ch         = c;
    r.ch_valid   = v;
    r.token_done = d;
    r.run_last   = l;
    return r;
  endfunction

  function automatic logic is_num_ch(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word_ch(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
  endfunction

  function automatic void emit(kind_e k, logic [7:0] c, logic v, logic d);
    if (step_q.size() < MaxRes) step_q.push_back(word(k, c, v, d, 1'b0));
  endfunction

  function automatic void lex_error();
    emit(K_ERROR, CH_NUL, 1'b0, 1'b0);
    lx_mode = M_DISC;
  endfunction

  // A character seen between tokens.
  function automatic void open_token(logic [7:0] c);
    if (c == CH_SPACE) begin
      sp_pend = 1'b1;
      return;
    end
    sp_pend = 1'b0;
    if (c == CH_OPEN) emit(K_OPEN, c, 1'b1, 1'b1);
    else if (c == CH_CLOSE) emit(K_CLOSE, c, 1'b1, 1'b1);
    else if (c == CH_COMMA) emit(K_COMMA, c, 1'b1, 1'b1);
    else if (c == CH_QUOTE) lx_mode = M_STR0;
    else if (is_num_ch(c)) begin
      lx_mode = M_NUM;
      emit(K_NUMBER, c, 1'b1, 1'b0);
    end else if (is_word_ch(c)) begin
      lx_mode = M_KEY;
      emit(K_KEYWORD, c, 1'b1, 1'b0);
    end else begin
      lex_error();
    end
  endfunction

  // Predicts the words that one accepted character causes, into step_q.
  function automatic void lex_char(logic [7:0] c, logic te);
    logic  has_ch;
    kind_e k;
    res_t  r;
    has_ch = !(te && c == CH_NUL);
    step_q.delete();
    if (has_ch) begin
      case (lx_mode)
        M_NUM: begin
          if (is_num_ch(c)) emit(K_NUMBER, c, 1'b1, 1'b0);
          else begin
            emit(K_NUMBER, CH_NUL, 1'b0, 1'b1);
            lx_mode = M_IDLE;
            open_token(c);
          end
        end
        M_KEY: begin
          if (is_word_ch(c)) emit(K_KEYWORD, c, 1'b1, 1'b0);
          else begin
            emit(K_KEYWORD, CH_NUL, 1'b0, 1'b1);
            lx_mode = M_IDLE;
            open_token(c);
          end
        end
        M_STR0: begin
          if (c == CH_QUOTE) lex_error();
          else if (!te) begin
            emit(K_STRING, c, 1'b1, 1'b0);
            lx_mode = M_STR;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            emit(K_STRING, CH_NUL, 1'b0, 1'b1);
            lx_mode = M_IDLE;
          end else if (!te) begin
            emit(K_STRING, c, 1'b1, 1'b0);
          end
        end
        M_IDLE: open_token(c);
        default: ;
      endcase
    end
    if (te) begin
      // A number or keyword still open is closed on its last character, or by a marker.
      if (lx_mode == M_NUM || lx_mode == M_KEY) begin
        if (lx_mode == M_NUM) k = K_NUMBER;
        else k = K_KEYWORD;
        if (step_q.size() > 0 && step_q[$].ch_valid && step_q[$].kind == k) begin
          r = step_q.pop_back();
          r.token_done = 1'b1;
          step_q.push_back(r);
        end else begin
          emit(k, CH_NUL, 1'b0, 1'b1);
        end
        lx_mode = M_IDLE;
      end
      if (lx_mode == M_STR0 || lx_mode == M_STR) lex_error();
      else if (lx_mode == M_IDLE) begin
        if (sp_pend) lex_error();
        else emit(K_END, CH_NUL, 1'b0, 1'b0);
      end
      lx_mode = M_IDLE;
      sp_pend = 1'b0;
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      step_q.push_back(r);
    end
  endfunction

  function automatic void add_row(logic [7:0] c, logic te, logic typed, res_t want);
    char_row_t row;
    row.ch    = c;
    row.te    = te;
    row.typed = typed;
    row.want  = want;
    rows_q.push_back(row);
  endfunction

  // Offers one character after a random gap and records what it should cause.
  task automatic send_char(char_row_t row);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.ch_in    <= row.ch;
    in_if.text_end <= row.te;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_chars++;
    lex_char(row.ch, row.te);
    if (step_q.size() > max_burst) max_burst = step_q.size();
    if (row.typed) words_due.push_back(row.want);
    else foreach (step_q[i]) words_due.push_back(step_q[i]);
    if (row.te) n_texts++;
  endtask

  function automatic logic [7:0] any_but_quote();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_QUOTE) c = 8'hA7;
    return c;
  endfunction

  function automatic void push_ch(logic [7:0] c);
    text_q.push_back('{ch: c, te: 1'b0, typed: 1'b0, want: RES_NONE});
  endfunction

  // Builds one random text, mostly well formed, sometimes broken on purpose.
  function automatic void gen_text();
    int         n_tok;
    int         len;
    int         r;
    int         pos;
    char_row_t  row;
    text_q.delete();
    n_tok = $urandom_range(0, 6);
    for (int t = 0; t < n_tok; t++) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 2)) push_ch(CH_SPACE);
      case ($urandom_range(0, 5))
        0: push_ch(CH_OPEN);
        1: push_ch(CH_CLOSE);
        2: push_ch(CH_COMMA);
        3: repeat ($urandom_range(1, 4)) push_ch(8'(8'h30 + $urandom_range(0, 9)));
        4: begin
          len = $urandom_range(1, 5);
          repeat (len) begin
            r = $urandom_range(0, 52);
            if (r < 26) push_ch(8'(8'h61 + r));
            else if (r < 52) push_ch(8'(8'h41 + r - 26));
            else push_ch(CH_UNDER);
          end
        end
        default: begin
          push_ch(CH_QUOTE);
          repeat ($urandom_range(1, 4)) push_ch(any_but_quote());
          push_ch(CH_QUOTE);
        end
      endcase
    end
    // Noise: stray bytes, cut-off strings, trailing spaces, empty strings.
    if ($urandom_range(0, 99) < 20) begin
      pos = $urandom_range(0, text_q.size());
      row = '{ch: 8'($urandom_range(0, 255)), te: 1'b0, typed: 1'b0, want: RES_NONE};
      case ($urandom_range(0, 3))
        0: text_q.insert(pos, row);
        1: if (text_q.size() > 0) void'(text_q.pop_back());
        2: repeat ($urandom_range(1, 3)) push_ch(CH_SPACE);
        default: begin
          row.ch = CH_QUOTE;
          text_q.insert(pos, row);
          text_q.insert(pos, row);
        end
      endcase
    end
    // The text ends either on its last character or on an empty end word.
    if (text_q.size() == 0 || $urandom_range(0, 2) == 0) begin
      text_q.push_back('{ch: CH_NUL, te: 1'b1, typed: 1'b0, want: RES_NONE});
    end else begin
      row = text_q.pop_back();
      row.te = 1'b1;
      text_q.push_back(row);
    end
  endfunction

  // Receiver: random ready with one long hold-off once random traffic starts.
  initial begin
    int  stall;
    bit  pressed;
    stall   = 0;
    pressed = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (press_go && !pressed) begin
        pressed = 1'b1;
        stall   = 120;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          stall--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  function automatic void report(string what, int want, int got);
    n_errs++;
    if (n_errs <= 30)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endfunction

  // Checks every accepted result word against the oldest predicted word.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_words++;
      kinds_seen[out_if.kind] = 1'b1;
      if (words_due.size() == 0) begin
        n_errs++;
        if (n_errs <= 30)
          $display("%0t: unexpected word: expected none, got kind %0d ch 0x%0h",
                   $time, out_if.kind, out_if.ch_out);
      end else begin
        want = words_due.pop_front();
        if (out_if.kind !== want.kind) report("kind", want.kind, out_if.kind);
        if (out_if.ch_out !== want.ch) report("ch_out", want.ch, out_if.ch_out);
        if (out_if.ch_valid !== want.ch_valid) report("ch_valid", want.ch_valid, out_if.ch_valid);
        if (out_if.token_done !== want.token_done)
          report("token_done", want.token_done, out_if.token_done);
        if (out_if.run_last !== want.run_last) report("run_last", want.run_last, out_if.run_last);
      end
    end
  end

  // Sender and run control.
  initial begin
    in_if.valid    = 1'b0;
    in_if.ch_in    = CH_NUL;
    in_if.text_end = 1'b0;
    rst_ni         = 1'b0;
    lx_mode        = M_IDLE;
    sp_pend        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed texts: empty text, single-character tokens, extremes of the
    // token classes, bytes zero and 0xFF inside a string, illegal character,
    // input dropped after an error, empty string, spaces only, missing close
    // quote, and a character that causes three words.
    add_row(CH_NUL, 1'b1, 1'b1, word(K_END, CH_NUL, 1'b0, 1'b0, 1'b1));
    add_row(CH_OPEN, 1'b0, 1'b1, word(K_OPEN, CH_OPEN, 1'b1, 1'b1, 1'b1));
    add_row(CH_CLOSE, 1'b0, 1'b1, word(K_CLOSE, CH_CLOSE, 1'b1, 1'b1, 1'b1));
    add_row(CH_COMMA, 1'b0, 1'b1, word(K_COMMA, CH_COMMA, 1'b1, 1'b1, 1'b1));
    add_row("0", 1'b0, 1'b0, RES_NONE);
    add_row("9", 1'b0, 1'b0, RES_NONE);
    add_row("A", 1'b0, 1'b0, RES_NONE);
    add_row("z", 1'b0, 1'b0, RES_NONE);
    add_row(CH_UNDER, 1'b0, 1'b0, RES_NONE);
    add_row(CH_SPACE, 1'b0, 1'b0, RES_NONE);
    add_row(CH_QUOTE, 1'b0, 1'b0, RES_NONE);
    add_row(CH_NUL, 1'b0, 1'b0, RES_NONE);
    add_row(8'hFF, 1'b0, 1'b0, RES_NONE);
    add_row(CH_QUOTE, 1'b0, 1'b0, RES_NONE);
    add_row("Z", 1'b1, 1'b0, RES_NONE);
    add_row(8'hFF, 1'b0, 1'b1, word(K_ERROR, CH_NUL, 1'b0, 1'b0, 1'b1));
    add_row("a", 1'b0, 1'b0, RES_NONE);
    add_row(CH_NUL, 1'b1, 1'b0, RES_NONE);
    add_row(CH_QUOTE, 1'b0, 1'b0, RES_NONE);
    add_row(CH_QUOTE, 1'b0, 1'b1, word(K_ERROR, CH_NUL, 1'b0, 1'b0, 1'b1));
    add_row("1", 1'b1, 1'b0, RES_NONE);
    add_row(CH_SPACE, 1'b1, 1'b1, word(K_ERROR, CH_NUL, 1'b0, 1'b0, 1'b1));
    add_row(CH_QUOTE, 1'b0, 1'b0, RES_NONE);
    add_row("q", 1'b1, 1'b1, word(K_ERROR, CH_NUL, 1'b0, 1'b0, 1'b1));
    add_row("5", 1'b0, 1'b0, RES_NONE);
    add_row(CH_OPEN, 1'b1, 1'b0, RES_NONE);
    foreach (rows_q[i]) send_char(rows_q[i]);

    // Random texts; the receiver holds off once so the input backs up.
    press_go = 1'b1;
    while (n_chars < NumChars) begin
      gen_text();
      foreach (text_q[i]) send_char(text_q[i]);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain, then let the checker go on watching so that anything extra shows.
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d characters in %0d texts, checked %0d result words.",
             n_chars, n_texts, n_words);
    $display("Kinds seen (bit per kind): %b, most words from one character: %0d.",
             kinds_seen, max_burst);
    if (n_errs == 0 && words_due.size() == 0) begin
      $display("** query_token_lexer: PASSED **");
    end else begin
      $display("%0d mismatches", n_errs);
      $display("** query_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule
